// ===== rtl/simdalu_pkg.sv =====
// ----------------------------------------------------------------------------
// simdalu_pkg
// Operation codes, lane controls and the operation decoder shared by the
// SIMD add/subtract unit, its submodules and its result checker.
// ----------------------------------------------------------------------------
package simdalu_pkg;

    typedef enum logic [4:0] {
        OP_ADD    = 5'd0,
        OP_ADDI   = 5'd1,
        OP_ADDIU  = 5'd2,
        OP_ADDU   = 5'd3,
        OP_DADD   = 5'd4,
        OP_DADDI  = 5'd5,
        OP_DADDIU = 5'd6,
        OP_DADDU  = 5'd7,
        OP_DSUB   = 5'd8,
        OP_DSUBU  = 5'd9,
        OP_SUB    = 5'd10,
        OP_SUBU   = 5'd11,
        OP_PADDB  = 5'd12,
        OP_PADDH  = 5'd13,
        OP_PADDSB = 5'd14,
        OP_PADDSH = 5'd15,
        OP_PADDSW = 5'd16,
        OP_PADDUB = 5'd17,
        OP_PADDUH = 5'd18,
        OP_PADDUW = 5'd19,
        OP_PADDW  = 5'd20,
        OP_PADSBH = 5'd21,
        OP_PSUBB  = 5'd22,
        OP_PSUBH  = 5'd23,
        OP_PSUBSB = 5'd24,
        OP_PSUBSH = 5'd25,
        OP_PSUBSW = 5'd26,
        OP_PSUBUB = 5'd27,
        OP_PSUBUH = 5'd28,
        OP_PSUBUW = 5'd29,
        OP_PSUBW  = 5'd30
    } op_t;

    typedef enum logic [1:0] {
        LW_8  = 2'd0,
        LW_16 = 2'd1,
        LW_32 = 2'd2
    } lane_width_t;

    typedef enum logic [1:0] {
        LK_WRAP = 2'd0,
        LK_SSAT = 2'd1,
        LK_USAT = 2'd2
    } lane_kind_t;

    typedef struct packed {
        lane_width_t width;
        lane_kind_t  kind;
    } lane_ctrl_t;

    typedef struct packed {
        logic       is_scalar;
        logic       is_parallel;
        logic       sub_lo;
        logic       sub_hi;
        lane_ctrl_t lane;
    } op_ctrl_t;

    function automatic op_ctrl_t decode_op(input logic [4:0] code);
        op_ctrl_t c;
        c.is_scalar   = 1'b0;
        c.is_parallel = 1'b1;
        c.sub_lo      = 1'b0;
        c.sub_hi      = 1'b0;
        c.lane.width  = LW_32;
        c.lane.kind   = LK_WRAP;
        unique case (op_t'(code))
            OP_ADD, OP_ADDI, OP_ADDIU, OP_ADDU, OP_DADD, OP_DADDI, OP_DADDIU,
            OP_DADDU, OP_DSUB, OP_DSUBU, OP_SUB, OP_SUBU:
            begin
                c.is_scalar   = 1'b1;
                c.is_parallel = 1'b0;
            end
            OP_PADDB:  c.lane = '{LW_8,  LK_WRAP};
            OP_PADDH:  c.lane = '{LW_16, LK_WRAP};
            OP_PADDSB: c.lane = '{LW_8,  LK_SSAT};
            OP_PADDSH: c.lane = '{LW_16, LK_SSAT};
            OP_PADDSW: c.lane = '{LW_32, LK_SSAT};
            OP_PADDUB: c.lane = '{LW_8,  LK_USAT};
            OP_PADDUH: c.lane = '{LW_16, LK_USAT};
            OP_PADDUW: c.lane = '{LW_32, LK_USAT};
            OP_PADDW:  c.lane = '{LW_32, LK_WRAP};
            OP_PADSBH:
            begin
                c.lane   = '{LW_16, LK_WRAP};
                c.sub_lo = 1'b1;
            end
            OP_PSUBB, OP_PSUBH, OP_PSUBSB, OP_PSUBSH, OP_PSUBSW, OP_PSUBUB,
            OP_PSUBUH, OP_PSUBUW, OP_PSUBW:
            begin
                c.sub_lo = 1'b1;
                c.sub_hi = 1'b1;
                unique case (op_t'(code))
                    OP_PSUBB:  c.lane = '{LW_8,  LK_WRAP};
                    OP_PSUBH:  c.lane = '{LW_16, LK_WRAP};
                    OP_PSUBSB: c.lane = '{LW_8,  LK_SSAT};
                    OP_PSUBSH: c.lane = '{LW_16, LK_SSAT};
                    OP_PSUBSW: c.lane = '{LW_32, LK_SSAT};
                    OP_PSUBUB: c.lane = '{LW_8,  LK_USAT};
                    OP_PSUBUH: c.lane = '{LW_16, LK_USAT};
                    OP_PSUBUW: c.lane = '{LW_32, LK_USAT};
                    default:   c.lane = '{LW_32, LK_WRAP};
                endcase
            end
            default:
            begin
                // Unused code: no operation, all result fields zero.
                c.is_parallel = 1'b0;
            end
        endcase
        return c;
    endfunction

endpackage

// ===== rtl/simdalu_if.sv =====
// ----------------------------------------------------------------------------
// simdalu_if
// Valid/ready channels carrying requests into and results out of the SIMD
// add/subtract unit.
// ----------------------------------------------------------------------------
interface simdalu_req_if;
    logic               valid;
    logic               ready;
    logic [4:0]         req_type;
    logic [63:0]        rs_lo;
    logic [63:0]        rs_hi;
    logic [63:0]        rt_lo;
    logic [63:0]        rt_hi;
    logic signed [15:0] immediate;

    modport source (output valid, req_type, rs_lo, rs_hi, rt_lo, rt_hi, immediate,
                    input ready);
    modport sink   (input valid, req_type, rs_lo, rs_hi, rt_lo, rt_hi, immediate,
                    output ready);
endinterface

interface simdalu_resp_if;
    logic        valid;
    logic        ready;
    logic [63:0] result_lo;
    logic [63:0] result_hi;
    logic        write_hi;
    logic        overflow;

    modport source (output valid, result_lo, result_hi, write_hi, overflow,
                    input ready);
    modport sink   (input valid, result_lo, result_hi, write_hi, overflow,
                    output ready);
endinterface

// ===== rtl/simdalu_scalar.sv =====
// ----------------------------------------------------------------------------
// simdalu_scalar
// Scalar 32-bit and 64-bit add/subtract with signed overflow detection for
// the trapping forms.
// ----------------------------------------------------------------------------
module simdalu_scalar
(
    input  logic [4:0]         op,
    input  logic [63:0]        a,
    input  logic [63:0]        b_reg_val,
    input  logic signed [15:0] imm,
    output logic [63:0]        result,
    output logic               overflow
);

    simdalu_pkg::op_t opc;
    logic        use_imm;
    logic        is_word;
    logic        is_sub;
    logic        is_trap;
    logic [63:0] b;
    logic [32:0] sum33;
    logic [63:0] sum64;
    logic        ovf32;
    logic        ovf64;

    assign opc = simdalu_pkg::op_t'(op);

    always_comb
    begin
        use_imm = 1'b0;
        is_word = 1'b0;
        is_sub  = 1'b0;
        is_trap = 1'b0;
        unique case (opc)
            simdalu_pkg::OP_ADD:    begin is_word = 1'b1; is_trap = 1'b1; end
            simdalu_pkg::OP_ADDI:
            begin
                is_word = 1'b1;
                is_trap = 1'b1;
                use_imm = 1'b1;
            end
            simdalu_pkg::OP_ADDIU:  begin is_word = 1'b1; use_imm = 1'b1; end
            simdalu_pkg::OP_ADDU:   is_word = 1'b1;
            simdalu_pkg::OP_DADD:   is_trap = 1'b1;
            simdalu_pkg::OP_DADDI:  begin is_trap = 1'b1; use_imm = 1'b1; end
            simdalu_pkg::OP_DADDIU: use_imm = 1'b1;
            simdalu_pkg::OP_DSUB:   begin is_sub = 1'b1; is_trap = 1'b1; end
            simdalu_pkg::OP_DSUBU:  is_sub = 1'b1;
            simdalu_pkg::OP_SUB:
            begin
                is_word = 1'b1;
                is_sub  = 1'b1;
                is_trap = 1'b1;
            end
            simdalu_pkg::OP_SUBU:   begin is_word = 1'b1; is_sub = 1'b1; end
            default:                is_trap = 1'b0;
        endcase
    end

    assign b = use_imm ? {{48{imm[15]}}, imm} : b_reg_val;

    // The 32-bit forms work on the true 33-bit result of the sign-extended words.
    assign sum33 = is_sub ? ({a[31], a[31:0]} - {b[31], b[31:0]})
                          : ({a[31], a[31:0]} + {b[31], b[31:0]});
    assign ovf32 = sum33[32] ^ sum33[31];

    assign sum64 = is_sub ? (a - b) : (a + b);
    assign ovf64 = is_sub ? ((a[63] ^ b[63]) & (a[63] ^ sum64[63]))
                          : (~(a[63] ^ b[63]) & (a[63] ^ sum64[63]));

    always_comb
    begin
        overflow = is_trap & (is_word ? ovf32 : ovf64);
        if (overflow)
            result = '0;
        else if (is_word)
            result = {{32{sum33[31]}}, sum33[31:0]};
        else
            result = sum64;
    end

endmodule

// ===== rtl/simdalu_lanes.sv =====
// ----------------------------------------------------------------------------
// simdalu_lanes
// One 64-bit half split into byte, halfword or word lanes, each added or
// subtracted with wrapping, signed saturation or unsigned saturation.
// ----------------------------------------------------------------------------
module simdalu_lanes
(
    input  logic [63:0]              x,
    input  logic [63:0]              y,
    input  simdalu_pkg::lane_ctrl_t  ctrl,
    input  logic                     sub,
    output logic [63:0]              z
);

    wire [63:0] z8;
    wire [63:0] z16;
    wire [63:0] z32;
    logic       ssat;
    logic       usat;

    assign ssat = (ctrl.kind == simdalu_pkg::LK_SSAT);
    assign usat = (ctrl.kind == simdalu_pkg::LK_USAT);

    for (genvar i = 0; i < 8; i++)
    begin : g_byte
        logic [7:0] a;
        logic [7:0] b;
        logic [8:0] s;
        logic       sovf;
        assign a    = x[8*i +: 8];
        assign b    = y[8*i +: 8];
        assign s    = sub ? ({1'b0, a} - {1'b0, b}) : ({1'b0, a} + {1'b0, b});
        assign sovf = (sub ? (a[7] ^ b[7]) : ~(a[7] ^ b[7])) & (s[7] ^ a[7]);
        assign z8[8*i +: 8] = (ssat && sovf) ? {a[7], {7{~a[7]}}}
                            : (usat && s[8]) ? (sub ? 8'h00 : 8'hFF)
                            : s[7:0];
    end

    for (genvar i = 0; i < 4; i++)
    begin : g_half
        logic [15:0] a;
        logic [15:0] b;
        logic [16:0] s;
        logic        sovf;
        assign a    = x[16*i +: 16];
        assign b    = y[16*i +: 16];
        assign s    = sub ? ({1'b0, a} - {1'b0, b}) : ({1'b0, a} + {1'b0, b});
        assign sovf = (sub ? (a[15] ^ b[15]) : ~(a[15] ^ b[15])) & (s[15] ^ a[15]);
        assign z16[16*i +: 16] = (ssat && sovf) ? {a[15], {15{~a[15]}}}
                               : (usat && s[16]) ? (sub ? 16'h0000 : 16'hFFFF)
                               : s[15:0];
    end

    for (genvar i = 0; i < 2; i++)
    begin : g_word
        logic [31:0] a;
        logic [31:0] b;
        logic [32:0] s;
        logic        sovf;
        assign a    = x[32*i +: 32];
        assign b    = y[32*i +: 32];
        assign s    = sub ? ({1'b0, a} - {1'b0, b}) : ({1'b0, a} + {1'b0, b});
        assign sovf = (sub ? (a[31] ^ b[31]) : ~(a[31] ^ b[31])) & (s[31] ^ a[31]);
        assign z32[32*i +: 32] = (ssat && sovf) ? {a[31], {31{~a[31]}}}
                               : (usat && s[32]) ? (sub ? 32'h0 : 32'hFFFF_FFFF)
                               : s[31:0];
    end

    always_comb
    begin
        unique case (ctrl.width)
            simdalu_pkg::LW_8:  z = z8;
            simdalu_pkg::LW_16: z = z16;
            default:            z = z32;
        endcase
    end

endmodule

// ===== rtl/simd_add_sub_alu_with_overflow_trap_unit.sv =====
// ----------------------------------------------------------------------------
// simd_add_sub_alu_with_overflow_trap_unit
// Add/subtract execute unit for a 64-bit core with 128-bit multimedia
// registers: scalar 32/64-bit forms with overflow trap and parallel lane forms.
// ----------------------------------------------------------------------------
// The unit takes one request transfer per clock when the result side is not
// stalled, and returns exactly one result transfer per request, in order, from
// the result register. A request is captured in an input register; the scalar
// adder and the two 64-bit lane units then work on it in a single pass of
// logic, and the answer is held in a result register. Both registers advance
// together whenever the result register is empty or its transfer completes, so
// a new request is taken every cycle while results are being taken. When a
// finished result waits, one further request can still be taken into an empty
// input register; after that the request side stalls until the result goes.
// Scalar operations write only result_lo (result_hi and write_hi are zero);
// trapping operations that overflow raise overflow and return zero data, and
// the destination must then not be written. Parallel operations set write_hi
// and never raise overflow. The unused operation code returns all zeros.
// ----------------------------------------------------------------------------
module simd_add_sub_alu_with_overflow_trap_unit
(
    input  logic            clk,
    input  logic            rst_n,
    simdalu_req_if.sink     req,
    simdalu_resp_if.source  resp
);

    // Pipeline advance: the result register is free or is being taken now.
    logic advance;

    // Input register.
    logic               in_valid_reg;
    logic [4:0]         op_reg;
    logic [63:0]        rs_lo_reg;
    logic [63:0]        rs_hi_reg;
    logic [63:0]        rt_lo_reg;
    logic [63:0]        rt_hi_reg;
    logic signed [15:0] imm_reg;
    logic               in_valid_next;

    // Result register.
    logic        out_valid_reg;
    logic [63:0] result_lo_reg;
    logic [63:0] result_hi_reg;
    logic        write_hi_reg;
    logic        overflow_reg;
    logic        out_valid_next;
    logic [63:0] result_lo_next;
    logic [63:0] result_hi_next;
    logic        write_hi_next;
    logic        overflow_next;

    // Datapath.
    simdalu_pkg::op_ctrl_t ctrl;
    logic [63:0]           scalar_result;
    logic                  scalar_ovf;
    logic [63:0]           lane_lo;
    logic [63:0]           lane_hi;

    assign advance   = !out_valid_reg || resp.ready;
    assign req.ready = !in_valid_reg || advance;

    assign in_valid_next  = req.ready ? req.valid : in_valid_reg;
    assign out_valid_next = advance ? in_valid_reg : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payloads load on each accepted request or advance; no reset needed.
    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            op_reg    <= req.req_type;
            rs_lo_reg <= req.rs_lo;
            rs_hi_reg <= req.rs_hi;
            rt_lo_reg <= req.rt_lo;
            rt_hi_reg <= req.rt_hi;
            imm_reg   <= req.immediate;
        end
        if (advance && in_valid_reg)
        begin
            result_lo_reg <= result_lo_next;
            result_hi_reg <= result_hi_next;
            write_hi_reg  <= write_hi_next;
            overflow_reg  <= overflow_next;
        end
    end

    assign ctrl = simdalu_pkg::decode_op(op_reg);

    simdalu_scalar u_scalar
    (
        .op        (op_reg),
        .a         (rs_lo_reg),
        .b_reg_val (rt_lo_reg),
        .imm       (imm_reg),
        .result    (scalar_result),
        .overflow  (scalar_ovf)
    );

    simdalu_lanes u_lanes_lo
    (
        .x    (rs_lo_reg),
        .y    (rt_lo_reg),
        .ctrl (ctrl.lane),
        .sub  (ctrl.sub_lo),
        .z    (lane_lo)
    );

    simdalu_lanes u_lanes_hi
    (
        .x    (rs_hi_reg),
        .y    (rt_hi_reg),
        .ctrl (ctrl.lane),
        .sub  (ctrl.sub_hi),
        .z    (lane_hi)
    );

    // Result selection: scalar, parallel, or all zeros for the unused code.
    always_comb
    begin
        result_lo_next = '0;
        result_hi_next = '0;
        write_hi_next  = 1'b0;
        overflow_next  = 1'b0;
        if (ctrl.is_scalar)
        begin
            result_lo_next = scalar_result;
            overflow_next  = scalar_ovf;
        end
        else if (ctrl.is_parallel)
        begin
            result_lo_next = lane_lo;
            result_hi_next = lane_hi;
            write_hi_next  = 1'b1;
        end
    end

    assign resp.valid     = out_valid_reg;
    assign resp.result_lo = result_lo_reg;
    assign resp.result_hi = result_hi_reg;
    assign resp.write_hi  = write_hi_reg;
    assign resp.overflow  = overflow_reg;

endmodule

// ===== sim/alu_result_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alu_result_checker
// Watches the request and result channels of the SIMD add/subtract unit,
// works out the expected result of every accepted request and compares each
// result transfer with the oldest outstanding expectation.
// ----------------------------------------------------------------------------
module alu_result_checker
(
    input  logic      clk,
    input  logic      rst_n,
    simdalu_req_if    req,
    simdalu_resp_if   resp,
    output int        fail_count,
    output int        pending
);

    typedef struct packed {
        logic [63:0] lo;
        logic [63:0] hi;
        logic        write_hi;
        logic        overflow;
    } alu_result_t;

    alu_result_t expected_q[$];
    alu_result_t want;

    // One 64-bit half cut into lanes of w bits.
    function automatic logic [63:0] lane_half(input logic [63:0] x, input logic [63:0] y,
                                              input int w,
                                              input simdalu_pkg::lane_kind_t kind,
                                              input bit sub);
        longint      mask;
        longint      sbit;
        longint      a;
        longint      b;
        longint      r;
        logic [63:0] acc;
        int          sh;
        mask = (longint'(1) << w) - 1;
        sbit = longint'(1) << (w - 1);
        acc  = '0;
        for (sh = 0; sh < 64; sh += w)
        begin
            a = longint'(x >> sh) & mask;
            b = longint'(y >> sh) & mask;
            if (kind == simdalu_pkg::LK_SSAT)
            begin
                if (a >= sbit) a = a - 2 * sbit;
                if (b >= sbit) b = b - 2 * sbit;
            end
            r = sub ? a - b : a + b;
            if (kind == simdalu_pkg::LK_SSAT)
            begin
                if (r > sbit - 1) r = sbit - 1;
                if (r < -sbit)    r = -sbit;
            end
            else if (kind == simdalu_pkg::LK_USAT)
            begin
                if (r < 0)    r = 0;
                if (r > mask) r = mask;
            end
            acc = acc | (64'(r & mask) << sh);
        end
        return acc;
    endfunction

    function automatic alu_result_t predict_alu(input logic [4:0] code,
                                                input logic [63:0] sl, input logic [63:0] sh,
                                                input logic [63:0] tl, input logic [63:0] th,
                                                input logic signed [15:0] imm);
        alu_result_t              res;
        logic [63:0]              b;
        logic [63:0]              r64;
        logic [63:0]              flags;
        logic signed [32:0]       a33;
        logic signed [32:0]       b33;
        logic signed [32:0]       r33;
        bit                       narrow;
        bit                       wide;
        bit                       trap;
        bit                       sub;
        int                       w;
        simdalu_pkg::lane_kind_t  kind;
        res    = '0;
        narrow = code inside {simdalu_pkg::OP_ADD, simdalu_pkg::OP_ADDI,
                              simdalu_pkg::OP_ADDIU, simdalu_pkg::OP_ADDU,
                              simdalu_pkg::OP_SUB, simdalu_pkg::OP_SUBU};
        wide   = code inside {simdalu_pkg::OP_DADD, simdalu_pkg::OP_DADDI,
                              simdalu_pkg::OP_DADDIU, simdalu_pkg::OP_DADDU,
                              simdalu_pkg::OP_DSUB, simdalu_pkg::OP_DSUBU};
        trap   = code inside {simdalu_pkg::OP_ADD, simdalu_pkg::OP_ADDI,
                              simdalu_pkg::OP_SUB, simdalu_pkg::OP_DADD,
                              simdalu_pkg::OP_DADDI, simdalu_pkg::OP_DSUB};
        sub    = code inside {simdalu_pkg::OP_SUB, simdalu_pkg::OP_SUBU,
                              simdalu_pkg::OP_DSUB, simdalu_pkg::OP_DSUBU};
        b      = code inside {simdalu_pkg::OP_ADDI, simdalu_pkg::OP_ADDIU,
                              simdalu_pkg::OP_DADDI, simdalu_pkg::OP_DADDIU} ?
                 {{48{imm[15]}}, imm} : tl;

        if (narrow)
        begin
            // The sum is formed on 33 bits so that overflow is judged on the true value.
            a33 = $signed({sl[31], sl[31:0]});
            b33 = $signed({b[31], b[31:0]});
            r33 = sub ? a33 - b33 : a33 + b33;
            if (trap && (r33[32] != r33[31]))
                res.overflow = 1'b1;
            else
                res.lo = {{32{r33[31]}}, r33[31:0]};
        end
        else if (wide)
        begin
            r64   = sub ? sl - b : sl + b;
            flags = sub ? ((sl ^ b) & (sl ^ r64)) : (~(sl ^ b) & (sl ^ r64));
            if (trap && flags[63])
                res.overflow = 1'b1;
            else
                res.lo = r64;
        end
        else if (code inside {[simdalu_pkg::OP_PADDB:simdalu_pkg::OP_PSUBW]})
        begin
            case (code)
                simdalu_pkg::OP_PADDB, simdalu_pkg::OP_PSUBB:
                begin
                    w = 8;  kind = simdalu_pkg::LK_WRAP;
                end
                simdalu_pkg::OP_PADDH, simdalu_pkg::OP_PSUBH, simdalu_pkg::OP_PADSBH:
                begin
                    w = 16; kind = simdalu_pkg::LK_WRAP;
                end
                simdalu_pkg::OP_PADDSB, simdalu_pkg::OP_PSUBSB:
                begin
                    w = 8;  kind = simdalu_pkg::LK_SSAT;
                end
                simdalu_pkg::OP_PADDSH, simdalu_pkg::OP_PSUBSH:
                begin
                    w = 16; kind = simdalu_pkg::LK_SSAT;
                end
                simdalu_pkg::OP_PADDSW, simdalu_pkg::OP_PSUBSW:
                begin
                    w = 32; kind = simdalu_pkg::LK_SSAT;
                end
                simdalu_pkg::OP_PADDUB, simdalu_pkg::OP_PSUBUB:
                begin
                    w = 8;  kind = simdalu_pkg::LK_USAT;
                end
                simdalu_pkg::OP_PADDUH, simdalu_pkg::OP_PSUBUH:
                begin
                    w = 16; kind = simdalu_pkg::LK_USAT;
                end
                simdalu_pkg::OP_PADDUW, simdalu_pkg::OP_PSUBUW:
                begin
                    w = 32; kind = simdalu_pkg::LK_USAT;
                end
                default:
                begin
                    w = 32; kind = simdalu_pkg::LK_WRAP;
                end
            endcase
            // The mixed halfword form subtracts in the low half and adds in the high one.
            res.lo       = lane_half(sl, tl, w, kind,
                                     code inside {[simdalu_pkg::OP_PADSBH:simdalu_pkg::OP_PSUBW]});
            res.hi       = lane_half(sh, th, w, kind,
                                     code inside {[simdalu_pkg::OP_PSUBB:simdalu_pkg::OP_PSUBW]});
            res.write_hi = 1'b1;
        end
        return res;
    endfunction

    task automatic check_field(input string name, input logic [63:0] exp_val,
                               input logic [63:0] act_val);
        if (act_val !== exp_val)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_val,
                     act_val);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            fail_count = 0;
            pending    = 0;
            expected_q.delete();
        end
        else
        begin
            // Results are taken first: a request accepted at this edge cannot be the
            // one that a result transfer at the same edge belongs to.
            if (resp.valid && resp.ready)
            begin
                if (expected_q.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual %h %h %b %b",
                             $time, resp.result_lo, resp.result_hi, resp.write_hi,
                             resp.overflow);
                    fail_count++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    check_field("result_lo", want.lo, resp.result_lo);
                    check_field("result_hi", want.hi, resp.result_hi);
                    check_field("write_hi", 64'(want.write_hi), 64'(resp.write_hi));
                    check_field("overflow", 64'(want.overflow), 64'(resp.overflow));
                end
            end
            if (req.valid && req.ready)
                expected_q.push_back(predict_alu(req.req_type, req.rs_lo, req.rs_hi,
                                                 req.rt_lo, req.rt_hi, req.immediate));
            pending = expected_q.size();
        end
    end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Top level for the SIMD add/subtract unit: drives requests through a short
// directed sweep of every operation code and then three randomised phases
// with varying back-pressure, and reports the verdict from the checker.
// ----------------------------------------------------------------------------
module tb;

    // The block holds at most two requests, so the run length is set purely by
    // the item count and the idling; the limit below is many times the slowest run.
    localparam int         CYCLE_LIMIT  = 200000;
    localparam int         RANDOM_ITEMS = 550;
    localparam int         HOLD_CYCLES  = 50;
    localparam logic [4:0] OP_UNUSED    = 5'd31;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // Percentages of cycles in which each side holds back, and a request for
    // one stretch in which the receiver refuses every transfer outright.
    int src_idle    = 0;
    int sink_idle   = 0;
    bit hold_now    = 1'b0;
    int cycle_count = 0;
    int fail_count;
    int pending;

    simdalu_req_if  req ();
    simdalu_resp_if resp ();

    simd_add_sub_alu_with_overflow_trap_unit dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .resp  (resp)
    );

    alu_result_checker u_check
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .resp       (resp),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Guard against a hang: the run is cut short and counted as a failure.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("simd_add_sub_alu_with_overflow_trap_unit verification failed");
            $finish;
        end
    end

    // Lane boundary values for a lane of w bits: signed maximum, signed minimum,
    // all ones, zero and one.
    function automatic logic [31:0] boundary_value(input int w, input int sel);
        logic [32:0] one;
        one = 33'd1;
        case (sel)
            0:       return 32'((one << (w - 1)) - 1);
            1:       return 32'(one << (w - 1));
            2:       return 32'((one << w) - 1);
            3:       return 32'd0;
            default: return 32'd1;
        endcase
    endfunction

    // Operands lean heavily on boundary lanes, all-ones or zero values and low words
    // near 32-bit limits so saturation and overflow are often hit; the rest is random.
    function automatic logic [63:0] random_operand();
        logic [63:0] v;
        int          w;
        int          k;
        v = '0;
        case ($urandom_range(0, 7))
            0, 1, 2: v = {$urandom, $urandom};
            3:       v = $urandom_range(0, 1) ? '1 : '0;
            4, 5, 6:
            begin
                w = 8 << $urandom_range(0, 2);
                for (k = 0; k < 64; k += w)
                    v = v | (64'(boundary_value(w, $urandom_range(0, 4))) << k);
            end
            default:
            begin
                // Low word close to the signed 32-bit limits, junk above it.
                v = {$urandom, boundary_value(32, $urandom_range(0, 1))
                               + 32'($urandom_range(0, 2)) - 32'd1};
            end
        endcase
        return v;
    endfunction

    function automatic logic signed [15:0] random_immediate();
        if ($urandom_range(0, 1) != 0)
            return 16'($urandom);
        return 16'(boundary_value(16, $urandom_range(0, 4)));
    endfunction

    // Offers one request and returns at the edge at which it is transferred.
    // Valid stays high from one request to the next unless the sender idles.
    task automatic send_request(input logic [4:0] code,
                                input logic [63:0] a_lo, input logic [63:0] a_hi,
                                input logic [63:0] b_lo, input logic [63:0] b_hi,
                                input logic signed [15:0] imm);
        while ($urandom_range(0, 99) < src_idle)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid     <= 1'b1;
        req.req_type  <= code;
        req.rs_lo     <= a_lo;
        req.rs_hi     <= a_hi;
        req.rt_lo     <= b_lo;
        req.rt_hi     <= b_hi;
        req.immediate <= imm;
        do
            @(posedge clk);
        while (req.ready !== 1'b1);
    endtask

    // Stops offering and waits until every outstanding result has been transferred.
    // One edge passes first so that the checker has counted the last request.
    task automatic wait_for_results();
        req.valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        @(posedge clk);
    endtask

    // Receiver: random refusal at the current rate, or a solid hold-off whose
    // length HOLD_CYCLES sets, once one has been asked for.
    initial
    begin
        int hold_left;
        bit hold_done;
        hold_left  = 0;
        hold_done  = 1'b0;
        resp.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_now && !hold_done)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                resp.ready <= 1'b0;
                hold_left--;
            end
            else
                resp.ready <= ($urandom_range(0, 99) >= sink_idle);
        end
    end

    initial
    begin
        logic [4:0]         code;
        logic [63:0]        a_lo;
        logic [63:0]        a_hi;
        logic [63:0]        b_lo;
        logic [63:0]        b_hi;
        logic signed [15:0] imm;
        int                 n;
        int                 phase;

        req.valid     = 1'b0;
        req.req_type  = '0;
        req.rs_lo     = '0;
        req.rs_hi     = '0;
        req.rt_lo     = '0;
        req.rt_hi     = '0;
        req.immediate = '0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed sweep: one request per operation code, each with operands
        // that push it to its interesting edge. The first phase's idling
        // applies here too.
        src_idle  = 31;
        sink_idle = 80;
        for (n = 0; n < 32; n++)
        begin
            code = 5'(n);
            a_lo = '0;
            a_hi = '1;
            b_lo = '0;
            b_hi = '1;
            imm  = '0;
            case (code)
                // Positive 32-bit overflow, with junk above the low word.
                simdalu_pkg::OP_ADD:
                begin
                    a_lo = 64'hDEAD_BEEF_7FFF_FFFF; b_lo = 64'd1;
                end
                // Negative 32-bit overflow through the most negative immediate.
                simdalu_pkg::OP_ADDI:
                begin
                    a_lo = 64'h0000_0000_8000_0000; imm = 16'sh8000;
                end
                simdalu_pkg::OP_ADDIU:
                begin
                    a_lo = 64'h0000_0000_7FFF_FFFF; imm = 16'sh7FFF;
                end
                simdalu_pkg::OP_ADDU:   begin a_lo = '1; b_lo = '1; end
                simdalu_pkg::OP_DADD:
                begin
                    a_lo = 64'h7FFF_FFFF_FFFF_FFFF; b_lo = 64'd1;
                end
                simdalu_pkg::OP_DADDI:
                begin
                    a_lo = 64'h8000_0000_0000_0000; imm = -16'sd1;
                end
                simdalu_pkg::OP_DADDIU: begin a_lo = '1; imm = 16'sd1; end
                simdalu_pkg::OP_DADDU:
                begin
                    a_lo = '1; b_lo = 64'h8000_0000_0000_0000;
                end
                simdalu_pkg::OP_DSUB:
                begin
                    a_lo = 64'h8000_0000_0000_0000; b_lo = 64'd1;
                end
                simdalu_pkg::OP_DSUBU:  begin a_lo = '0; b_lo = 64'd1; end
                simdalu_pkg::OP_SUB:
                begin
                    a_lo = 64'h0000_0000_8000_0000; b_lo = 64'd1;
                end
                // The difference has its top bit set and must be sign-extended.
                simdalu_pkg::OP_SUBU:
                begin
                    a_lo = '0; b_lo = 64'h0000_0000_8000_0000;
                end
                OP_UNUSED: begin a_lo = '1; b_lo = '1; imm = -16'sd1; end
                default:
                begin
                    // Lane patterns that saturate at every lane width.
                    a_lo = 64'h7F80_FF00_7FFF_8000;
                    a_hi = 64'h8000_0000_7FFF_FFFF;
                    b_lo = 64'h01FF_0180_0001_FFFF;
                    b_hi = 64'h7FFF_FFFF_8000_0001;
                end
            endcase
            send_request(code, a_lo, a_hi, b_lo, b_hi, imm);
        end
        wait_for_results();

        // Random phases: sender slow and receiver very slow, then the reverse,
        // then both at full rate with one long receiver hold-off that fills the
        // block and stalls its input. The sender drains after each phase.
        for (phase = 0; phase < 3; phase++)
        begin
            src_idle  = (phase == 0) ? 31 : (phase == 1) ? 80 : 0;
            sink_idle = (phase == 0) ? 80 : (phase == 1) ? 31 : 0;
            for (n = 0; n < RANDOM_ITEMS / 3; n++)
            begin
                if (phase == 2 && n == 40)
                    hold_now = 1'b1;
                send_request(5'($urandom_range(0, 31)), random_operand(), random_operand(),
                             random_operand(), random_operand(), random_immediate());
            end
            wait_for_results();
        end

        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("simd_add_sub_alu_with_overflow_trap_unit verification clean");
        else
            $display("simd_add_sub_alu_with_overflow_trap_unit verification failed");
        $finish;
    end

endmodule

// ===== simd_add_sub_alu_with_overflow_trap_unit.f =====
rtl/simdalu_pkg.sv
rtl/simdalu_if.sv
rtl/simdalu_scalar.sv
rtl/simdalu_lanes.sv
rtl/simd_add_sub_alu_with_overflow_trap_unit.sv
sim/alu_result_checker.sv
sim/tb.sv
